// ===== rtl/digital_input_debounce_remap_defines.svh =====
// Assertion macros for the debounce and remap block.
`ifndef DIGITAL_INPUT_DEBOUNCE_REMAP_DEFINES_SVH
`define DIGITAL_INPUT_DEBOUNCE_REMAP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DBR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dbr_pkg.sv =====
// Shared constants, register map and types for the debounce and remap block.
`default_nettype none

package dbr_pkg;

   localparam int NUM_PINS_DEF     = 7;
   localparam int COUNT_BITS_DEF   = 10;
   localparam int FUNC_BITS_DEF    = 21;

   localparam int MAP_FIELD_BITS   = 5;
   localparam int SMALL_MODEL_PINS = 5;
   localparam logic [MAP_FIELD_BITS-1:0] FUNC_DRIVE_ENABLE = 5'd0;
   localparam logic [MAP_FIELD_BITS-1:0] FUNC_ACDC_A       = 5'd16;
   localparam logic [MAP_FIELD_BITS-1:0] FUNC_ACDC_B       = 5'd17;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_INPUT_INVERT   = 5'd0,
      CSR_DEBOUNCE_LIMIT = 5'd8,
      CSR_FULL_MODEL     = 5'd16,
      CSR_FUNCTION_MAP   = 5'd24
   } csr_addr_type;

   typedef struct packed {
      logic acdc_assigned;
      logic drive_enable_assigned;
   } map_flags_type;

endpackage

`default_nettype wire

// ===== rtl/dbr_debounce.sv =====
// Per-pin debounce counters and stable level register.
`default_nettype none

module dbr_debounce #(
   parameter int NUM_PINS   = dbr_pkg::NUM_PINS_DEF,
   parameter int COUNT_BITS = dbr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [NUM_PINS-1:0]   sample,
   input  wire logic [COUNT_BITS-1:0] limit,
   output logic      [NUM_PINS-1:0]   stable_in
);
   import dbr_pkg::*;

   logic [COUNT_BITS-1:0] count_ff [NUM_PINS];
   logic [COUNT_BITS-1:0] count_in [NUM_PINS];
   logic [NUM_PINS-1:0]   stable_ff;

   always_comb begin
      for (int i = 0; i < NUM_PINS; i++) begin
         stable_in[i] = stable_ff[i];
         if (sample[i] == stable_ff[i]) begin
            count_in[i] = '0;
         end else if (count_ff[i] >= limit) begin
            // adopt the new level once it has persisted long enough
            count_in[i]  = '0;
            stable_in[i] = sample[i];
         end else begin
            count_in[i] = count_ff[i] + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= '0;
         for (int i = 0; i < NUM_PINS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (step) begin
         stable_ff <= stable_in;
         for (int i = 0; i < NUM_PINS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dbr_remap.sv =====
// Places stable pin levels at their function bit positions and derives the map flags.
`default_nettype none

module dbr_remap #(
   parameter int NUM_PINS  = dbr_pkg::NUM_PINS_DEF,
   parameter int FUNC_BITS = dbr_pkg::FUNC_BITS_DEF
) (
   input  wire logic [NUM_PINS-1:0]                        stable,
   input  wire logic [NUM_PINS*dbr_pkg::MAP_FIELD_BITS-1:0] function_map,
   output logic      [FUNC_BITS-1:0]                       function_word,
   output dbr_pkg::map_flags_type                          flags
);
   import dbr_pkg::*;

   logic [MAP_FIELD_BITS-1:0] pos [NUM_PINS];

   always_comb begin
      function_word = '0;
      flags         = '0;
      for (int i = 0; i < NUM_PINS; i++) begin
         pos[i] = function_map[i*MAP_FIELD_BITS +: MAP_FIELD_BITS];
         if (pos[i] == FUNC_DRIVE_ENABLE) begin
            flags.drive_enable_assigned = 1'b1;
         end
         if (pos[i] == FUNC_ACDC_A || pos[i] == FUNC_ACDC_B) begin
            flags.acdc_assigned = 1'b1;
         end
         // positions at or above the word width match no bit and drop out
         for (int b = 0; b < FUNC_BITS; b++) begin
            if (stable[i] && pos[i] == MAP_FIELD_BITS'(b)) begin
               function_word[b] = 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/digital_input_debounce_remap.sv =====
// Top level of the debounced, remapped digital input block.
// Each req transaction carries one sample of the raw input pins. The block
// inverts each pin by input_invert, masks to the five low pins when full_model
// is 0, runs a debounce counter per pin (a changed pin is adopted once its
// counter has reached debounce_limit, so a limit of 0 adopts at once) and
// places the stable levels into a function word at the positions given by
// function_map, five bits per pin, pin 0 lowest. Both map flags look at every
// pin's position regardless of its level. One rsp transaction follows every
// req transaction. The block takes one sample per clock cycle while the result
// register is not stalled: all pin counters update in parallel between an input
// register and a result register, and a stalled result register holds while
// one more sample waits in the input register.
// Configuration registers (APB, 64-bit data, byte addresses 0, 8, 16, 24):
// input_invert, debounce_limit, full_model, function_map; write them only
// while no transaction is in flight.
`default_nettype none

module digital_input_debounce_remap #(
   parameter int NUM_PINS   = dbr_pkg::NUM_PINS_DEF,
   parameter int COUNT_BITS = dbr_pkg::COUNT_BITS_DEF,
   parameter int FUNC_BITS  = dbr_pkg::FUNC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: raw_pins
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [((NUM_PINS+7)/8)*8-1:0]     req_tdata,
   // rsp_tdata: stable_levels, function_word, drive_enable_assigned, acdc_assigned
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [((NUM_PINS+FUNC_BITS+2+7)/8)*8-1:0] rsp_tdata,
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [dbr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [dbr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [dbr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import dbr_pkg::*;

`include "digital_input_debounce_remap_defines.svh"

   localparam int RSP_W = ((NUM_PINS+FUNC_BITS+2+7)/8)*8;
   localparam int MAP_W = NUM_PINS*MAP_FIELD_BITS;

   // configuration registers
   logic [NUM_PINS-1:0]   invert_ff;
   logic [COUNT_BITS-1:0] limit_ff;
   logic                  full_model_ff;
   logic [MAP_W-1:0]      map_ff;
   logic                  csr_write;

   // input stage
   logic                s1_valid_ff;
   logic [NUM_PINS-1:0] s1_raw_ff;
   logic                s1_advance;

   // result stage
   logic                 rsp_valid_ff;
   logic [NUM_PINS-1:0]  rsp_stable_ff;
   logic [FUNC_BITS-1:0] rsp_word_ff;
   map_flags_type        rsp_flags_ff;

   // datapath between the stages
   logic [NUM_PINS-1:0]  model_mask;
   logic [NUM_PINS-1:0]  sample;
   logic [NUM_PINS-1:0]  stable_in;
   logic [FUNC_BITS-1:0] word_in;
   map_flags_type        flags_in;

   // ---------------------------------------------------------------
   // Configuration port: write on the access phase, reads are direct.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff     <= '0;
         limit_ff      <= '0;
         full_model_ff <= 1'b1;
         map_ff        <= '0;
      end else if (csr_write) begin
         case (csr_addr_type'(csr_paddr))
            CSR_INPUT_INVERT:   invert_ff     <= csr_pwdata[NUM_PINS-1:0];
            CSR_DEBOUNCE_LIMIT: limit_ff      <= csr_pwdata[COUNT_BITS-1:0];
            CSR_FULL_MODEL:     full_model_ff <= csr_pwdata[0];
            CSR_FUNCTION_MAP:   map_ff        <= MAP_W'(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_addr_type'(csr_paddr))
         CSR_INPUT_INVERT:   csr_prdata = CSR_DATA_BITS'(invert_ff);
         CSR_DEBOUNCE_LIMIT: csr_prdata = CSR_DATA_BITS'(limit_ff);
         CSR_FULL_MODEL:     csr_prdata = CSR_DATA_BITS'(full_model_ff);
         CSR_FUNCTION_MAP:   csr_prdata = CSR_DATA_BITS'(map_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Flow control: the input stage advances whenever the result
   // register is empty or being drained this cycle.
   // ---------------------------------------------------------------
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // hold the raw sample until it moves on
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_raw_ff <= req_tdata[NUM_PINS-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Polarity and model masking.
   // ---------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < NUM_PINS; i++) begin
         model_mask[i] = full_model_ff || (i < SMALL_MODEL_PINS);
      end
      sample = (s1_raw_ff ^ invert_ff) & model_mask;
   end

   // counters advance only when a sample moves into the result register
   dbr_debounce #(
      .NUM_PINS   (NUM_PINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_debounce (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_valid_ff && s1_advance),
      .sample    (sample),
      .limit     (limit_ff),
      .stable_in (stable_in)
   );

   dbr_remap #(
      .NUM_PINS  (NUM_PINS),
      .FUNC_BITS (FUNC_BITS)
   ) u_remap (
      .stable        (stable_in),
      .function_map  (map_ff),
      .function_word (word_in),
      .flags         (flags_in)
   );

   // ---------------------------------------------------------------
   // Result register: hold while the consumer stalls.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_stable_ff <= stable_in;
         rsp_word_ff   <= word_in;
         rsp_flags_ff  <= flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_flags_ff.acdc_assigned,
                               rsp_flags_ff.drive_enable_assigned,
                               rsp_word_ff, rsp_stable_ff});

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `DBR_ASSERT_NEXT(a_s1_kept, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff, "sample lost in input stage")
   `DBR_ASSERT_NEXT(a_s1_to_rsp, clock, reset, s1_valid_ff && s1_advance, rsp_valid_ff, "sample did not reach result register")
   `DBR_ASSERT_SAME(a_word_from_pins, clock, reset, rsp_valid_ff && rsp_word_ff != '0, rsp_stable_ff != '0, "function word set with no stable pin")

endmodule

`default_nettype wire

// ===== tb/digital_input_debounce_remap_checker.sv =====
// Checker that predicts the debounced levels and function word and compares them.
`timescale 1ns / 1ps

module digital_input_debounce_remap_checker (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_tvalid,
   input  logic                                             req_tready,
   // req_tdata: raw_pins
   input  logic [((dbr_pkg::NUM_PINS_DEF+7)/8)*8-1:0]       req_tdata,
   input  logic                                             rsp_tvalid,
   input  logic                                             rsp_tready,
   // rsp_tdata: stable_levels, function_word, drive_enable_assigned, acdc_assigned
   input  logic [((dbr_pkg::NUM_PINS_DEF+dbr_pkg::FUNC_BITS_DEF+2+7)/8)*8-1:0] rsp_tdata,
   input  logic                                             csr_psel,
   input  logic                                             csr_penable,
   input  logic                                             csr_pwrite,
   input  logic [dbr_pkg::CSR_ADDR_BITS-1:0]                csr_paddr,
   input  logic [dbr_pkg::CSR_DATA_BITS-1:0]                csr_pwdata,
   input  logic                                             csr_pready,
   output int unsigned                                      mismatches,
   output int unsigned                                      results_owed
);
   import dbr_pkg::*;

   localparam int PINS   = NUM_PINS_DEF;
   localparam int FUNCS  = FUNC_BITS_DEF;
   localparam int COUNTW = COUNT_BITS_DEF;
   localparam int MAPW   = PINS * MAP_FIELD_BITS;
   localparam logic [PINS-1:0] SMALL_PIN_MASK = PINS'((1 << SMALL_MODEL_PINS) - 1);

   // Packed in the order of rsp_tdata, stable levels in the lowest bits.
   typedef struct packed {
      logic             acdc;
      logic             drive_enable;
      logic [FUNCS-1:0] word;
      logic [PINS-1:0]  levels;
   } pin_outputs_type;

   logic [PINS-1:0]   invert_cfg = '0;
   logic [COUNTW-1:0] limit_cfg  = '0;
   logic              full_cfg   = 1'b1;
   logic [MAPW-1:0]   map_cfg    = '0;

   logic [PINS-1:0]   stable_pins = '0;
   logic [COUNTW-1:0] pin_counts [PINS];

   pin_outputs_type   owed_outputs [$];
   int unsigned       samples_taken = 0;
   int unsigned       results_seen  = 0;

   initial mismatches = 0;
   assign results_owed = samples_taken - results_seen;

   // Advance every pin counter by one sample, then place the stable pins.
   function automatic pin_outputs_type debounce_and_map(input logic [PINS-1:0] raw);
      logic [PINS-1:0]           asserted;
      logic [MAP_FIELD_BITS-1:0] pos;
      pin_outputs_type           outs;
      asserted = raw ^ invert_cfg;
      if (!full_cfg) asserted &= SMALL_PIN_MASK;
      outs = '0;
      for (int i = 0; i < PINS; i++) begin
         if (asserted[i] == stable_pins[i]) begin
            pin_counts[i] = '0;
         end else if (pin_counts[i] >= limit_cfg) begin
            pin_counts[i]  = '0;
            stable_pins[i] = asserted[i];
         end else begin
            pin_counts[i] = pin_counts[i] + 1'b1;
         end
      end
      for (int i = 0; i < PINS; i++) begin
         pos = map_cfg[i*MAP_FIELD_BITS +: MAP_FIELD_BITS];
         if (pos == FUNC_DRIVE_ENABLE) outs.drive_enable = 1'b1;
         if (pos == FUNC_ACDC_A || pos == FUNC_ACDC_B) outs.acdc = 1'b1;
         if (stable_pins[i] && pos < FUNCS) outs.word[pos] = 1'b1;
      end
      outs.levels = stable_pins;
      return outs;
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      pin_outputs_type owed;
      pin_outputs_type seen;
      if (reset) begin
         invert_cfg  = '0;
         limit_cfg   = '0;
         full_cfg    = 1'b1;
         map_cfg     = '0;
         stable_pins = '0;
         for (int i = 0; i < PINS; i++) pin_counts[i] = '0;
         owed_outputs.delete();
         samples_taken <= 0;
         results_seen  <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               CSR_INPUT_INVERT:   invert_cfg = csr_pwdata[PINS-1:0];
               CSR_DEBOUNCE_LIMIT: limit_cfg  = csr_pwdata[COUNTW-1:0];
               CSR_FULL_MODEL:     full_cfg   = csr_pwdata[0];
               CSR_FUNCTION_MAP:   map_cfg    = csr_pwdata[MAPW-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            seen = pin_outputs_type'(rsp_tdata[$bits(pin_outputs_type)-1:0]);
            if (owed_outputs.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result transaction, expected none, got 0x%0h",
                        $time, rsp_tdata);
            end else begin
               owed = owed_outputs.pop_front();
               check_field("stable_levels", 32'(owed.levels), 32'(seen.levels));
               check_field("function_word", 32'(owed.word), 32'(seen.word));
               check_field("drive_enable_assigned", 32'(owed.drive_enable),
                           32'(seen.drive_enable));
               check_field("acdc_assigned", 32'(owed.acdc), 32'(seen.acdc));
            end
         end
         if (req_tvalid && req_tready) begin
            samples_taken <= samples_taken + 1;
            owed_outputs.push_back(debounce_and_map(req_tdata[PINS-1:0]));
         end
      end
   end

endmodule

// ===== tb/digital_input_debounce_remap_test.sv =====
// Top of the debounce and remap testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module digital_input_debounce_remap_test;
   import dbr_pkg::*;

   localparam int PINS  = NUM_PINS_DEF;
   localparam int MAPW  = PINS * MAP_FIELD_BITS;
   localparam int REQ_W = ((NUM_PINS_DEF + 7) / 8) * 8;
   localparam int RSP_W = ((NUM_PINS_DEF + FUNC_BITS_DEF + 2 + 7) / 8) * 8;

   // Margin after the last result has come through the block.
   localparam int RESULT_TAIL    = 6;
   // Receiver hold-off must be long enough to back the block up into its input.
   localparam int RX_HOLD_CYCLES = 300;
   // Cycles without any transaction before the run is declared hung.
   localparam int STALL_LIMIT    = 2000;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   // req_tdata: raw_pins
   logic [REQ_W-1:0]         req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   // rsp_tdata: stable_levels, function_word, drive_enable_assigned, acdc_assigned
   logic [RSP_W-1:0]         rsp_tdata;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int unsigned              mismatches;
   int unsigned              results_owed;

   // Shared between the sender and the receiver: random idling on or off,
   // and a request for one long receiver hold-off.
   bit                       idling_on       = 1'b0;
   bit                       rx_hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   digital_input_debounce_remap u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   digital_input_debounce_remap_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   // Offer one pin sample and hold it until the block takes the transaction.
   // An occasional gap drops tvalid first; it is raised again in a later step.
   task automatic send_sample(input logic [PINS-1:0] raw);
      if (idling_on && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(raw);
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every predicted result has been taken.
   // The first edge lets the checker count the last accepted sample.
   task automatic settle_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (RESULT_TAIL) @(posedge clock);
   endtask

   // One APB write: setup cycle, access cycle, then release the bus.
   task automatic csr_write(input csr_addr_type addr, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [PINS-1:0] invert, input int unsigned limit,
                                 input bit full, input logic [MAPW-1:0] fmap);
      csr_write(CSR_INPUT_INVERT, CSR_DATA_BITS'(invert));
      csr_write(CSR_DEBOUNCE_LIMIT, CSR_DATA_BITS'(limit));
      csr_write(CSR_FULL_MODEL, CSR_DATA_BITS'(full));
      csr_write(CSR_FUNCTION_MAP, CSR_DATA_BITS'(fmap));
   endtask

   // Bias each pin's position toward the flag functions and the dropped
   // high positions so both flags and the overflow case show up often.
   function automatic logic [MAPW-1:0] random_function_map();
      logic [MAPW-1:0]           fmap;
      logic [MAP_FIELD_BITS-1:0] pos;
      fmap = '0;
      for (int i = 0; i < PINS; i++) begin
         case ($urandom_range(0, 9))
            0, 1:    pos = FUNC_DRIVE_ENABLE;
            2:       pos = FUNC_ACDC_A;
            3:       pos = FUNC_ACDC_B;
            4:       pos = MAP_FIELD_BITS'($urandom_range(FUNC_BITS_DEF, 31));
            default: pos = MAP_FIELD_BITS'($urandom_range(1, FUNC_BITS_DEF - 1));
         endcase
         fmap[i*MAP_FIELD_BITS +: MAP_FIELD_BITS] = pos;
      end
      return fmap;
   endfunction

   // One random phase: fresh settings, then runs of a steady pin pattern at most
   // three longer than the limit capped at 16, with occasional one-pin glitches.
   // Short runs double as noise. Optionally ask for the long receiver hold-off.
   task automatic random_phase(input int unsigned n_items, input bit with_hold);
      logic [PINS-1:0] level;
      logic [PINS-1:0] raw;
      int unsigned     limit;
      int unsigned     run;
      int unsigned     sent;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: limit = $urandom_range(0, 3);
         5, 6, 7, 8:    limit = $urandom_range(4, 12);
         default:       limit = $urandom_range(13, 1023);
      endcase
      write_settings(PINS'($urandom_range(0, 127)), limit, ($urandom_range(0, 3) != 0),
                     random_function_map());
      sent = 0;
      while (sent < n_items) begin
         level = PINS'($urandom_range(0, 127));
         run   = $urandom_range(1, ((limit < 16) ? limit : 16) + 3);
         for (int k = 0; k < run; k++) begin
            raw = level;
            if ($urandom_range(0, 9) == 0) raw ^= PINS'(1 << $urandom_range(0, PINS - 1));
            // Back up the block while the sender keeps offering samples.
            if (with_hold && sent == 10) rx_hold_request = 1'b1;
            send_sample(raw);
            sent++;
         end
      end
      settle_results();
   endtask

   // Receiver: ready most cycles, a random one-cycle stall now and then, and
   // on request one long hold-off counted here.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (rx_hold_request) begin
            rsp_tready <= 1'b0;
            for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clock);
            rx_hold_request = 1'b0;
         end
         rsp_tready <= !(idling_on && $urandom_range(0, 99) < 6);
      end
   end

   // Watchdog: end the run when nothing moves on any channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("digital_input_debounce_remap_test: done, errors");
      $finish;
   end

   initial begin : stimulus
      // Hold reset, then release it for good.
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: no limit, full model, every pin at function 0, so
      // function bit 0 is the OR of all stable pins and the drive flag is set.
      send_sample(7'h00);
      send_sample(7'h7F);
      send_sample(7'h7F);
      send_sample(7'h00);
      send_sample(7'h55);
      send_sample(7'h2A);
      send_sample(7'h7F);
      settle_results();

      // Small model, all pins active low: pins 5 and 6 can never assert but
      // their positions still raise the AC/DC flag. Pins 1 and 2 sit at
      // positions past the function word and must drop out of it.
      write_settings(7'h7F, 0, 1'b0,
                     {FUNC_ACDC_B, FUNC_ACDC_A, 5'd10, 5'd1, 5'd31, 5'd21, 5'd20});
      send_sample(7'h7F);
      send_sample(7'h00);
      send_sample(7'h1F);
      send_sample(7'h60);
      settle_results();

      // Counter bound: clear all pins, build a count of three under a limit of
      // six, then lower the limit to one so the next differing sample adopts.
      write_settings(7'h00, 0, 1'b1, {5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0});
      send_sample(7'h00);
      settle_results();
      csr_write(CSR_DEBOUNCE_LIMIT, CSR_DATA_BITS'(6));
      send_sample(7'h7F);
      send_sample(7'h7F);
      send_sample(7'h7F);
      settle_results();
      csr_write(CSR_DEBOUNCE_LIMIT, CSR_DATA_BITS'(1));
      send_sample(7'h7F);
      send_sample(7'h00);
      send_sample(7'h00);
      settle_results();

      // Random part: the first phase with no idling at all, then idling on
      // both sides, one phase with the long receiver hold-off.
      random_phase(60, 1'b0);
      idling_on = 1'b1;
      random_phase(55, 1'b0);
      random_phase(55, 1'b1);
      random_phase(55, 1'b0);
      random_phase(55, 1'b0);
      random_phase(55, 1'b0);

      // Largest limit: a run of differing samples far shorter than the limit
      // must leave every pin at its level. Every map field at the top
      // position, so the word stays clear.
      write_settings(7'h55, 0, 1'b1, '1);
      send_sample(7'h00);
      send_sample(7'h00);
      settle_results();
      csr_write(CSR_DEBOUNCE_LIMIT, CSR_DATA_BITS'(1023));
      for (int k = 0; k < 20; k++) send_sample(7'h7F);
      send_sample(7'h00);
      settle_results();

      if (mismatches == 0 && results_owed == 0)
         $display("digital_input_debounce_remap_test: done, clean");
      else
         $display("digital_input_debounce_remap_test: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dbr_pkg.sv
rtl/dbr_debounce.sv
rtl/dbr_remap.sv
rtl/digital_input_debounce_remap.sv
tb/digital_input_debounce_remap_checker.sv
tb/digital_input_debounce_remap_test.sv
